FILE: hdl/arlt_pkg.sv
// ----------------------------------------------------------------------------
// arlt_pkg: shared types and constants
// Status codes, register indexes, entry layout for the rate lock table.
// ----------------------------------------------------------------------------
package arlt_pkg;

    localparam int DEF_TABLE_ENTRIES = 256;

    localparam logic [2:0] ST_QUERY    = 3'd0;
    localparam logic [2:0] ST_NEW      = 3'd1;
    localparam logic [2:0] ST_BUMP     = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_DISABLED = 3'd4;

    localparam logic [0:0] REG_LOCK_DELAY = 1'd0;
    localparam logic [0:0] REG_HIT_LIMIT  = 1'd1;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // one stored entry: v4, hi, lo, stamp, hits
    localparam int ENTRY_W = 1 + 64 + 64 + 32 + 8;

    typedef struct packed {
        logic        v4;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [31:0] stamp;
        logic [7:0]  hits;
    } entry_t;

endpackage

FILE: hdl/address_rate_lock_table.sv
// ----------------------------------------------------------------------------
// address_rate_lock_table: per-address hit counters with expiry
// Ring of entries in insertion order, swept from the oldest end, searched
// one entry at a time by a single ram port and one compare unit.
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  request   start, busy, op, addr_hi, addr_lo,        in (busy out)
//            is_v4, now_sec
//  result    done, locked, status                      out, one cycle strobe
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data in (cfg_ready out)
//
// A request holds busy while it sweeps expired entries from the oldest end,
// searches the remaining entries and does the update; sweep and search
// together cover at most TABLE_ENTRIES entries, and done rises in the cycle
// in which busy falls. The single ram port makes the search serial. A
// disabled table raises done in the cycle right after start is taken. Config
// writes are taken only while busy is low. Reset clears head, fill, sweep
// time, delay and outputs, sets the hit limit to 1; no ram clearing pass.
// The receiver cannot stall: done lasts exactly one cycle.
// ----------------------------------------------------------------------------
module address_rate_lock_table
    import arlt_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  logic [63:0] addr_hi,
    input  logic [63:0] addr_lo,
    input  logic        is_v4,
    input  logic [31:0] now_sec,
    output logic        done,
    output logic        locked,
    output logic [2:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int FW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [FW-1:0] FULL = FW'(TABLE_ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE, S_SW_RD, S_SW_CHK, S_FD_RD, S_FD_CHK, S_UPD
    } state_t;

    state_t      state_reg;
    logic [15:0] delay_reg;
    logic [7:0]  limit_reg;
    logic [AW-1:0] head_reg;
    logic [FW-1:0] fill_reg;
    logic [31:0] last_reg;
    logic [FW-1:0] k_reg;
    logic        op_reg;
    entry_t      key_reg;
    logic        found_reg;
    logic [AW-1:0] slot_reg;
    entry_t      hit_reg;

    logic        ram_we;
    logic [AW-1:0] ram_addr;
    entry_t      ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t      rd;

    assign rd = entry_t'(ram_rdata);
    assign cfg_ready = !busy;

    // slot of ring position k, wrapping at any depth
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h,
                                              input logic [FW-1:0] k);
        logic [FW:0] s;
        s = FW'(h) + k;
        if (s >= (FW+1)'(TABLE_ENTRIES))
        begin
            s = s - (FW+1)'(TABLE_ENTRIES);
        end
        return s[AW-1:0];
    endfunction

    // ram port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = key_reg;
        ram_addr  = head_reg;
        unique case (state_reg)
            S_FD_RD:  ram_addr = slot_of(head_reg, k_reg);
            S_UPD:
            begin
                if (op_reg == OP_ADD && found_reg)
                begin
                    ram_addr  = slot_reg;
                    ram_wdata = hit_reg;
                    ram_we    = hit_reg.hits < limit_reg;
                    ram_wdata.hits = hit_reg.hits + 8'd1;
                end
                else if (op_reg == OP_ADD && fill_reg != FULL)
                begin
                    ram_addr = slot_of(head_reg, fill_reg);
                    ram_we   = 1'b1;
                end
            end
            default:  ram_addr = head_reg;
        endcase
    end

    arlt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign busy = state_reg != S_IDLE;

    // sequencer, state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            delay_reg <= 16'd0;
            limit_reg <= 8'd1;
            head_reg  <= '0;
            fill_reg  <= '0;
            last_reg  <= '0;
            done      <= 1'b0;
            locked    <= 1'b0;
            status    <= ST_QUERY;
        end
        else
        begin
            done <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_LOCK_DELAY)
                    delay_reg <= cfg_data;
                else
                    limit_reg <= cfg_data[7:0];
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg       <= op;
                        key_reg.v4   <= is_v4;
                        key_reg.hi   <= is_v4 ? 64'd0 : addr_hi;
                        key_reg.lo   <= is_v4 ? {32'd0, addr_lo[31:0]} : addr_lo;
                        key_reg.stamp <= now_sec;
                        key_reg.hits <= 8'd1;
                        found_reg    <= 1'b0;
                        k_reg        <= '0;
                        if (delay_reg == 16'd0)
                        begin
                            done   <= 1'b1;
                            locked <= 1'b0;
                            status <= ST_DISABLED;
                        end
                        else if (last_reg != 32'd0 && now_sec == last_reg)
                            state_reg <= S_FD_RD;
                        else
                        begin
                            last_reg  <= now_sec;
                            state_reg <= S_SW_RD;
                        end
                    end
                end
                S_SW_RD:
                begin
                    if (fill_reg == '0)
                        state_reg <= S_FD_RD;
                    else
                        state_reg <= S_SW_CHK;
                end
                S_SW_CHK:
                begin
                    if (key_reg.stamp - rd.stamp > {16'd0, delay_reg})
                    begin
                        head_reg  <= slot_of(head_reg, FW'(1));
                        fill_reg  <= fill_reg - FW'(1);
                        state_reg <= S_SW_RD;
                    end
                    else
                        state_reg <= S_FD_RD;
                end
                S_FD_RD:
                begin
                    if (k_reg == fill_reg)
                        state_reg <= S_UPD;
                    else
                    begin
                        slot_reg  <= slot_of(head_reg, k_reg);
                        state_reg <= S_FD_CHK;
                    end
                end
                S_FD_CHK:
                begin
                    if (rd.v4 == key_reg.v4 && rd.hi == key_reg.hi && rd.lo == key_reg.lo)
                    begin
                        found_reg <= 1'b1;
                        hit_reg   <= rd;
                        state_reg <= S_UPD;
                    end
                    else
                    begin
                        k_reg     <= k_reg + FW'(1);
                        state_reg <= S_FD_RD;
                    end
                end
                S_UPD:
                begin
                    done      <= 1'b1;
                    locked    <= 1'b0;
                    state_reg <= S_IDLE;
                    if (op_reg == OP_QUERY)
                    begin
                        status <= ST_QUERY;
                        locked <= found_reg
                            && (key_reg.stamp - hit_reg.stamp <= {16'd0, delay_reg})
                            && hit_reg.hits >= limit_reg;
                    end
                    else if (found_reg)
                        status <= ST_BUMP;
                    else if (fill_reg != FULL)
                    begin
                        status   <= ST_NEW;
                        fill_reg <= fill_reg + FW'(1);
                    end
                    else
                        status <= ST_FULL;
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: hdl/arlt_ram.sv
// ----------------------------------------------------------------------------
// arlt_ram: generic single port ram
// One access per cycle: optional write, registered read data of the old contents.
// ----------------------------------------------------------------------------
module arlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for address_rate_lock_table
// Drives add and query requests with random gaps through several register
// settings, predicts every status and lock bit, and compares each result.
// ----------------------------------------------------------------------------
module tb;
    import arlt_pkg::*;

    typedef struct {
        logic       locked;
        logic [2:0] status;
    } lock_result_t;

    // predictor of the rate lock table and store of expected results
    class lock_table_model;
        logic [63:0]  ent_hi    [256];
        logic [63:0]  ent_lo    [256];
        logic         ent_v4    [256];
        logic [31:0]  ent_stamp [256];
        logic [7:0]   ent_hits  [256];
        int           head;
        int           fill;
        logic [31:0]  last_sweep;
        logic [15:0]  delay;
        logic [7:0]   limit;
        lock_result_t expected_q[$];
        int           errors;
        int           seen[8];

        function new();
            head = 0;
            fill = 0;
            last_sweep = '0;
            delay = '0;
            limit = 8'd1;
            errors = 0;
            foreach (seen[i]) seen[i] = 0;
        endfunction

        function void write_reg(logic [0:0] idx, logic [15:0] data);
            if (idx == REG_LOCK_DELAY) delay = data;
            else if (idx == REG_HIT_LIMIT) limit = data[7:0];
        endfunction

        // work out the result of one accepted request
        function void note_request(logic opc, logic [63:0] hi_in, logic [63:0] lo_in,
                                   logic v4, logic [31:0] now);
            lock_result_t r;
            logic [63:0]  hi;
            logic [63:0]  lo;
            logic [31:0]  age;
            int           hit;
            int           s;
            hi = v4 ? 64'd0 : hi_in;
            lo = v4 ? {32'd0, lo_in[31:0]} : lo_in;
            r.locked = 1'b0;
            hit = -1;
            if (delay == 0) begin
                r.status = ST_DISABLED;
            end else begin
                // expire from the oldest end whenever the time differs from the last sweep or that is zero
                if (!(last_sweep != 0 && now == last_sweep)) begin
                    last_sweep = now;
                    while (fill > 0) begin
                        age = now - ent_stamp[head];
                        if (age <= {16'd0, delay}) break;
                        head = (head + 1) % 256;
                        fill--;
                    end
                end
                for (int k = 0; k < fill && hit < 0; k++) begin
                    s = (head + k) % 256;
                    if (ent_v4[s] == v4 && ent_hi[s] == hi && ent_lo[s] == lo) hit = s;
                end
                if (opc == OP_QUERY) begin
                    if (hit >= 0) begin
                        age = now - ent_stamp[hit];
                        if (age <= {16'd0, delay} && ent_hits[hit] >= limit)
                            r.locked = 1'b1;
                    end
                    r.status = ST_QUERY;
                end else if (hit >= 0) begin
                    if (ent_hits[hit] < limit) ent_hits[hit]++;
                    r.status = ST_BUMP;
                end else if (fill < 256) begin
                    s = (head + fill) % 256;
                    ent_hi[s] = hi;
                    ent_lo[s] = lo;
                    ent_v4[s] = v4;
                    ent_stamp[s] = now;
                    ent_hits[s] = 8'd1;
                    fill++;
                    r.status = ST_NEW;
                end else begin
                    r.status = ST_FULL;
                end
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(logic lk, logic [2:0] st);
            lock_result_t e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result locked=%0b status=%0d", $time, lk, st);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            seen[e.status]++;
            if (lk !== e.locked) begin
                $display("%0t: locked mismatch expected %0b actual %0b",
                         $time, e.locked, lk);
                errors++;
            end
            if (st !== e.status) begin
                $display("%0t: status mismatch expected %0d actual %0d",
                         $time, e.status, st);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        op;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic        is_v4;
    logic [31:0] now_sec;
    logic        done;
    logic        locked;
    logic [2:0]  status;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;

    lock_table_model lock_model = new();
    logic [31:0] cur_time;
    logic [63:0] pool_hi [16];
    logic [63:0] pool_lo [16];
    logic        pool_v4 [16];
    int          requests;

    address_rate_lock_table DUT (.*);

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // result monitor
    always @(posedge clk) begin
        if (rst_n && done) lock_model.check_result(locked, status);
    end

    // issue one request; start is left high after acceptance
    task automatic send_request(logic opc, logic [63:0] hi, logic [63:0] lo,
                                logic v4, logic [31:0] now);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        op      <= opc;
        addr_hi <= hi;
        addr_lo <= lo;
        is_v4   <= v4;
        now_sec <= now;
        do @(posedge clk); while (busy);
        lock_model.note_request(opc, hi, lo, v4, now);
        requests++;
    endtask

    // write one register once all outstanding results are back
    task automatic write_reg(logic [0:0] idx, logic [15:0] data);
        start <= 1'b0;
        while (lock_model.expected_q.size() != 0) @(posedge clk);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        lock_model.write_reg(idx, data);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(logic [15:0] dly, logic [15:0] lim);
        write_reg(REG_LOCK_DELAY, dly);
        write_reg(REG_HIT_LIMIT, lim);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // random traffic over a small address pool with time that stays or advances and can also step back
    task automatic random_phase(int count, logic [15:0] dly);
        int          pick;
        int          sel;
        logic [63:0] hi;
        logic [63:0] lo;
        logic        v4;
        foreach (pool_hi[i]) begin
            pool_hi[i] = rand64();
            pool_lo[i] = rand64();
            pool_v4[i] = $urandom_range(0, 1);
        end
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 9);
            if (sel >= 5 && sel <= 7)
                cur_time += $urandom_range(1, dly);
            else if (sel == 8)
                cur_time += $urandom_range(dly + 1, 2 * dly + 2);
            else if (sel == 9 && $urandom_range(0, 7) == 0)
                cur_time -= $urandom_range(1, 3);
            if ($urandom_range(0, 4) == 0) begin
                hi = rand64();
                lo = rand64();
                v4 = $urandom_range(0, 1);
            end else begin
                pick = $urandom_range(0, 15);
                // ipv4 upper bits are noise and must not matter
                hi = pool_v4[pick] ? rand64() : pool_hi[pick];
                lo = pool_v4[pick] ? {$urandom(), pool_lo[pick][31:0]} : pool_lo[pick];
                v4 = pool_v4[pick];
            end
            send_request($urandom_range(0, 2) == 0 ? OP_QUERY : OP_ADD, hi, lo, v4, cur_time);
        end
    endtask

    initial begin
        logic [63:0] a_hi;
        logic [63:0] a_lo;
        rst_n     = 1'b0;
        start     = 1'b0;
        op        = OP_ADD;
        addr_hi   = '0;
        addr_lo   = '0;
        is_v4     = 1'b0;
        now_sec   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_LOCK_DELAY;
        cfg_data  = '0;
        requests  = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // disabled table after reset
        send_request(OP_ADD, '1, '1, 1'b0, 32'd0);
        send_request(OP_QUERY, '0, '0, 1'b1, '1);

        // directed: new, bump, lock, ipv4 equality, expiry, time going back
        set_regs(16'd5, 16'd2);
        a_hi = rand64();
        a_lo = rand64();
        send_request(OP_QUERY, '1, '1, 1'b0, 32'd0);
        send_request(OP_ADD, '1, '1, 1'b0, 32'd0);
        send_request(OP_ADD, '0, '0, 1'b0, 32'd0);
        send_request(OP_ADD, '1, '1, 1'b0, 32'd0);
        send_request(OP_ADD, '1, '1, 1'b0, 32'd0);
        send_request(OP_QUERY, '1, '1, 1'b0, 32'd1);
        send_request(OP_ADD, a_hi, a_lo, 1'b1, 32'd2);
        send_request(OP_ADD, ~a_hi, {~a_lo[63:32], a_lo[31:0]}, 1'b1, 32'd3);
        send_request(OP_QUERY, '0, a_lo, 1'b1, 32'd3);
        send_request(OP_QUERY, '0, a_lo, 1'b0, 32'd3);
        send_request(OP_QUERY, '1, '1, 1'b0, 32'd5);
        send_request(OP_QUERY, '1, '1, 1'b0, 32'd6);
        send_request(OP_ADD, a_hi, a_lo, 1'b1, 32'd8);
        send_request(OP_QUERY, a_hi, a_lo, 1'b1, 32'd1);
        send_request(OP_ADD, a_hi, a_lo, 1'b1, 32'd0);
        send_request(OP_QUERY, a_hi, a_lo, 1'b1, 32'd0);

        // fill the table to overflow, then random traffic
        set_regs(16'hFFFF, 16'd255);
        cur_time = 32'hFFFF_FF00;
        for (int n = 0; n < 270; n++)
            send_request(OP_ADD, rand64(), rand64(), $urandom_range(0, 1), cur_time);
        random_phase(80, 16'd300);

        set_regs(16'd1, 16'd1);
        random_phase(250, 16'd1);
        set_regs(16'd0, 16'd3);
        random_phase(40, 16'd4);
        set_regs(16'd20, 16'd3);
        random_phase(300, 16'd20);
        set_regs(16'd4, 16'd255);
        random_phase(200, 16'd4);
        set_regs(16'd60, 16'd2);
        random_phase(300, 16'd60);
        set_regs(16'd7, 16'd170);
        random_phase(140, 16'd7);

        start <= 1'b0;
        while (lock_model.expected_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (lock_model.expected_q.size() != 0) lock_model.errors++;

        $display("requests %0d: query %0d, new %0d, bump %0d, full %0d, disabled %0d",
                 requests, lock_model.seen[ST_QUERY], lock_model.seen[ST_NEW],
                 lock_model.seen[ST_BUMP], lock_model.seen[ST_FULL],
                 lock_model.seen[ST_DISABLED]);
        if (lock_model.errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #80_000_000;
        $display("tb failed");
        $finish;
    end

endmodule
